[src/stt_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// stt_pkg: shared types and constants of the source text tokenizer
// Request and response payloads, the paired result entry, token kinds
// and the keyword and operator tables.
// ----------------------------------------------------------------------------
package stt_pkg;

   localparam int POSITION_BITS_DEF   = 16;
   localparam int KEYWORD_MAX_LEN_DEF = 5;

   localparam int OP_COUNT = 7;
   localparam int KW_COUNT = 7;

   localparam logic [4:0] KIND_NUMBER  = 5'd7;
   localparam logic [4:0] KIND_IDENT   = 5'd8;
   localparam logic [4:0] KIND_KW_BASE = 5'd9;
   localparam logic [4:0] KIND_END     = 5'd16;
   localparam logic [4:0] KIND_BAD     = 5'd17;
   localparam logic [4:0] KIND_OVF     = 5'd18;

   localparam logic [34:0] NUM_LIMIT = 35'd2147483647;
   localparam logic [15:0] LEN_SAT   = 16'hFFFF;

   // operator characters, in token kind order
   localparam logic [7:0] OP_CHARS [OP_COUNT] = '{
      8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h28, 8'h29, 8'h3B
   };

   // keywords, first character in the lowest byte
   localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
      64'h0000_0000_0074_656C,   // let
      64'h0000_0074_6E69_7270,   // print
      64'h0000_0065_6C69_6877,   // while
      64'h0000_0000_0000_6F64,   // do
      64'h0000_0000_0064_6E65,   // end
      64'h0000_0000_0000_6669,   // if
      64'h0000_0000_6E65_6874    // then
   };
   localparam logic [15:0] KW_LEN [KW_COUNT] = '{
      16'd3, 16'd5, 16'd5, 16'd2, 16'd3, 16'd2, 16'd4
   };

   typedef struct packed {
      logic [7:0] char_code;
      logic       end_mark;
   } req_type;

   typedef struct packed {
      logic [4:0]  token_kind;
      logic [30:0] number_value;
      logic [15:0] token_start;
      logic [15:0] token_length;
      logic [7:0]  bad_char;
      logic        last;
   } rsp_type;

   // results caused by one request
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } pair_type;

endpackage
`default_nettype wire

[src/stt_scan.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// stt_scan: scanner state and per-byte token logic
// Holds the open run and the byte position, and forms up to two results
// for each accepted request in the same cycle.
// ----------------------------------------------------------------------------
module stt_scan #(
   parameter int POSITION_BITS   = stt_pkg::POSITION_BITS_DEF,
   parameter int KEYWORD_MAX_LEN = stt_pkg::KEYWORD_MAX_LEN_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire stt_pkg::req_type  req,
   output stt_pkg::pair_type      pair
);

   localparam int PrefixBits = KEYWORD_MAX_LEN * 8;

   localparam logic [1:0] MODE_IDLE  = 2'd0;
   localparam logic [1:0] MODE_NUM   = 2'd1;
   localparam logic [1:0] MODE_IDENT = 2'd2;
   localparam logic [1:0] MODE_ERR   = 2'd3;

   localparam logic [7:0] CH_0  = 8'h30;
   localparam logic [7:0] CH_9  = 8'h39;
   localparam logic [7:0] CH_UA = 8'h41;
   localparam logic [7:0] CH_UZ = 8'h5A;
   localparam logic [7:0] CH_LA = 8'h61;
   localparam logic [7:0] CH_LZ = 8'h7A;
   localparam logic [7:0] CH_US = 8'h5F;
   localparam logic [7:0] CH_SP = 8'h20;
   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_CR  = 8'h0D;

   logic [1:0]               mode_ff, mode_in;
   logic [30:0]              acc_ff, acc_in;
   logic                     ovf_ff, ovf_in;
   logic [POSITION_BITS-1:0] start_ff, start_in;
   logic [15:0]              len_ff, len_in;
   logic [PrefixBits-1:0]    prefix_ff, prefix_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;

   logic [7:0]       c;
   logic [7:0]       c_lower;
   logic             is_digit, is_alpha, is_space, id_first, id_next;
   logic [34:0]      prod;
   logic [15:0]      len_bump;
   logic [4:0]       kw_kind;
   logic             op_hit;
   logic [4:0]       op_kind;
   stt_pkg::rsp_type close_res, char_res, end_res;
   logic             has_close, has_char;

   assign c        = req.char_code;
   assign is_digit = (c >= CH_0) && (c <= CH_9);
   assign is_alpha = ((c >= CH_UA) && (c <= CH_UZ)) || ((c >= CH_LA) && (c <= CH_LZ));
   assign is_space = (c == CH_SP) || ((c >= CH_TAB) && (c <= CH_CR));
   assign id_first = is_alpha || (c == CH_US);
   assign id_next  = id_first || is_digit;
   assign c_lower  = ((c >= CH_UA) && (c <= CH_UZ)) ? c + 8'd32 : c;
   assign prod     = (35'(acc_ff) << 3) + (35'(acc_ff) << 1) + 35'(c - CH_0);
   assign len_bump = (len_ff == stt_pkg::LEN_SAT) ? len_ff : len_ff + 16'd1;

   always_comb begin
      kw_kind = stt_pkg::KIND_IDENT;
      for (int i = 0; i < stt_pkg::KW_COUNT; i++) begin
         if (len_ff == stt_pkg::KW_LEN[i] &&
             prefix_ff == stt_pkg::KW_TEXT[i][PrefixBits-1:0]) begin
            kw_kind = stt_pkg::KIND_KW_BASE + 5'(i);
         end
      end
   end

   always_comb begin
      op_hit  = 1'b0;
      op_kind = '0;
      for (int i = 0; i < stt_pkg::OP_COUNT; i++) begin
         if (c == stt_pkg::OP_CHARS[i]) begin
            op_hit  = 1'b1;
            op_kind = 5'(i);
         end
      end
   end

   always_comb begin
      close_res              = '0;
      close_res.token_start  = 16'(start_ff);
      close_res.token_length = len_ff;
      if (mode_ff == MODE_NUM) begin
         if (ovf_ff) begin
            close_res.token_kind = stt_pkg::KIND_OVF;
         end else begin
            close_res.token_kind   = stt_pkg::KIND_NUMBER;
            close_res.number_value = acc_ff;
         end
      end else begin
         close_res.token_kind = kw_kind;
      end

      end_res             = '0;
      end_res.token_kind  = stt_pkg::KIND_END;
      end_res.token_start = 16'(pos_ff);
   end

   always_comb begin
      mode_in   = mode_ff;
      acc_in    = acc_ff;
      ovf_in    = ovf_ff;
      start_in  = start_ff;
      len_in    = len_ff;
      prefix_in = prefix_ff;
      pos_in    = pos_ff + POSITION_BITS'(1);
      has_close = 1'b0;
      has_char  = 1'b0;
      char_res              = '0;
      char_res.token_start  = 16'(pos_ff);
      char_res.token_length = 16'd1;

      if (req.end_mark) begin
         has_close = (mode_ff == MODE_NUM) || (mode_ff == MODE_IDENT);
         has_char  = 1'b1;
         char_res  = end_res;
         mode_in   = MODE_IDLE;
         acc_in    = '0;
         ovf_in    = 1'b0;
         start_in  = '0;
         len_in    = '0;
         prefix_in = '0;
         pos_in    = '0;
      end else if (mode_ff == MODE_ERR) begin
         mode_in = MODE_ERR;
      end else if (mode_ff == MODE_NUM && is_digit) begin
         if (!ovf_ff) begin
            if (prod > stt_pkg::NUM_LIMIT) begin
               ovf_in = 1'b1;
            end else begin
               acc_in = prod[30:0];
            end
         end
         len_in = len_bump;
      end else if (mode_ff == MODE_IDENT && id_next) begin
         for (int b = 0; b < KEYWORD_MAX_LEN; b++) begin
            if (len_ff == 16'(b)) begin
               prefix_in[b*8 +: 8] = c_lower;
            end
         end
         len_in = len_bump;
      end else if (mode_ff == MODE_NUM && ovf_ff) begin
         // overflowed run ends: report it, drop this byte
         has_close = 1'b1;
         mode_in   = MODE_ERR;
      end else begin
         has_close = (mode_ff != MODE_IDLE);
         mode_in   = MODE_IDLE;
         if (op_hit) begin
            has_char            = 1'b1;
            char_res.token_kind = op_kind;
         end else if (is_space) begin
            mode_in = MODE_IDLE;
         end else if (is_digit) begin
            mode_in   = MODE_NUM;
            acc_in    = 31'(c - CH_0);
            ovf_in    = 1'b0;
            start_in  = pos_ff;
            len_in    = 16'd1;
            prefix_in = '0;
         end else if (id_first) begin
            mode_in   = MODE_IDENT;
            acc_in    = '0;
            ovf_in    = 1'b0;
            start_in  = pos_ff;
            len_in    = 16'd1;
            prefix_in = PrefixBits'(c_lower);
         end else begin
            has_char            = 1'b1;
            char_res.token_kind = stt_pkg::KIND_BAD;
            char_res.bad_char   = c;
            mode_in             = MODE_ERR;
         end
      end
   end

   always_comb begin
      pair = '0;
      if (has_close && has_char) begin
         pair.count       = 2'd2;
         pair.first       = close_res;
         pair.second      = char_res;
         pair.second.last = 1'b1;
      end else if (has_close) begin
         pair.count      = 2'd1;
         pair.first      = close_res;
         pair.first.last = 1'b1;
      end else if (has_char) begin
         pair.count      = 2'd1;
         pair.first      = char_res;
         pair.first.last = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         acc_ff    <= '0;
         ovf_ff    <= 1'b0;
         start_ff  <= '0;
         len_ff    <= '0;
         prefix_ff <= '0;
         pos_ff    <= '0;
      end else if (accept) begin
         mode_ff   <= mode_in;
         acc_ff    <= acc_in;
         ovf_ff    <= ovf_in;
         start_ff  <= start_in;
         len_ff    <= len_in;
         prefix_ff <= prefix_in;
         pos_ff    <= pos_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (accept && req.end_mark) |=> (mode_ff == MODE_IDLE && pos_ff == '0))
      else $error("end of source did not restart the scanner");

   assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_ERR) |=> (mode_ff == MODE_ERR || $past(accept && req.end_mark)))
      else $error("left error mode without end of source");

   assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_NUM && !ovf_ff) |-> (35'(acc_ff) <= stt_pkg::NUM_LIMIT))
      else $error("number accumulator above limit without overflow flag");

endmodule
`default_nettype wire

[src/stt_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// stt_queue: two-entry response queue
// Holds the result pairs of accepted requests and hands them out one
// response at a time.
// ----------------------------------------------------------------------------
module stt_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire stt_pkg::pair_type  push_data,
   output logic                    full,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output stt_pkg::rsp_type        rsp_data
);

   stt_pkg::pair_type entry_ff [2];
   stt_pkg::pair_type head;
   logic       wr_ptr_ff, rd_ptr_ff;
   logic       sub_ff, sub_in;
   logic [1:0] count_ff, count_in;
   logic       pop, pop_item;

   assign head      = entry_ff[rd_ptr_ff];
   assign full      = (count_ff == 2'd2);
   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = sub_ff ? head.second : head.first;
   assign pop       = rsp_valid && !rsp_stall;
   assign pop_item  = pop && (sub_ff || head.count == 2'd1);

   always_comb begin
      count_in = count_ff + 2'(push) - 2'(pop_item);
      sub_in   = sub_ff;
      if (pop) begin
         sub_in = !pop_item;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         sub_ff    <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff ^ push;
         rd_ptr_ff <= rd_ptr_ff ^ pop_item;
         sub_ff    <= sub_in;
         count_ff  <= count_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      push |-> (!full && push_data.count != 2'd0))
      else $error("push into full queue or empty pair");

   assert property (@(posedge clock) disable iff (reset)
      sub_ff |-> (rsp_valid && head.count == 2'd2))
      else $error("second response selected without a pair");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.last == (sub_ff || head.count == 2'd1)))
      else $error("last flag out of step with the pair");

   assert property (@(posedge clock) disable iff (reset)
      (pop_item && !push) |=> (count_ff == $past(count_ff) - 2'd1))
      else $error("queue count did not drop on pop");

endmodule
`default_nettype wire

[src/source_text_tokenizer.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// source_text_tokenizer: streaming lexical analyzer
// Takes one source byte per request and returns number, identifier,
// keyword, operator, end and error tokens.
// ----------------------------------------------------------------------------
// A request is taken every cycle while req_stall is low: each byte is
// scanned in the cycle it is accepted, and its tokens, if any, go as one
// entry into a two-entry response queue, so with the queue empty the
// response channel shows a token the cycle after the request. A request
// that gives two tokens hands them out one after the other, so sustained
// rate is one request per cycle as long as requests average at most one
// token; the response port, one token per cycle while rsp_stall is low,
// sets the limit otherwise. req_stall rises only while both queue entries are occupied.
module source_text_tokenizer #(
   parameter int POSITION_BITS   = stt_pkg::POSITION_BITS_DEF,
   parameter int KEYWORD_MAX_LEN = stt_pkg::KEYWORD_MAX_LEN_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire stt_pkg::req_type  req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output stt_pkg::rsp_type       rsp_data
);

   logic              accept;
   logic              full;
   stt_pkg::pair_type pair;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   stt_scan #(
      .POSITION_BITS   (POSITION_BITS),
      .KEYWORD_MAX_LEN (KEYWORD_MAX_LEN)
   ) u_scan (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .pair   (pair)
   );

   stt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept && pair.count != 2'd0),
      .push_data (pair),
      .full      (full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

[tb/source_text_tokenizer_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// source_text_tokenizer_test: self-checking bench of the source text tokenizer
// Feeds short source texts byte by byte: keywords in mixed case, identifiers,
// numbers up to and past the overflow limit, operators, whitespace and stray
// bytes, plus two long runs. A scoreboard predicts every token and
// checks the response stream while both sides idle and stall at random.
// ----------------------------------------------------------------------------

typedef enum logic [1:0] {SCAN_IDLE, SCAN_NUMBER, SCAN_IDENT, SCAN_ERROR} scan_mode_type;

localparam int PREFIX_BITS = 8 * stt_pkg::KEYWORD_MAX_LEN_DEF;

localparam logic [7:0] CH_TAB        = 8'h09;
localparam logic [7:0] CH_CR         = 8'h0D;
localparam logic [7:0] CH_SPACE      = 8'h20;
localparam logic [7:0] CH_ZERO       = 8'h30;
localparam logic [7:0] CH_NINE       = 8'h39;
localparam logic [7:0] CH_UPPER_A    = 8'h41;
localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
localparam logic [7:0] CH_LOWER_A    = 8'h61;
localparam logic [7:0] CH_LOWER_Z    = 8'h7A;
localparam logic [7:0] CASE_GAP      = 8'h20;

class token_scoreboard;
   scan_mode_type          mode;
   logic [31:0]            value_acc;
   bit                     overflowed;
   logic [15:0]            run_start;
   logic [15:0]            run_len;
   logic [15:0]            next_pos;
   logic [PREFIX_BITS-1:0] prefix;
   stt_pkg::rsp_type       pending_tokens[$];
   int                     failures;

   function new();
      failures = 0;
      restart();
   endfunction

   function void restart();
      mode       = SCAN_IDLE;
      value_acc  = '0;
      overflowed = 1'b0;
      run_start  = '0;
      run_len    = '0;
      next_pos   = '0;
      prefix     = '0;
   endfunction

   function void push_token(logic [4:0] kind, logic [30:0] value, logic [15:0] start,
                            logic [15:0] len, logic [7:0] bad);
      stt_pkg::rsp_type t;
      t.token_kind   = kind;
      t.number_value = value;
      t.token_start  = start;
      t.token_length = len;
      t.bad_char     = bad;
      t.last         = 1'b0;
      pending_tokens = {pending_tokens, t};
   endfunction

   function void close_run();
      logic [4:0] kind;
      if (mode == SCAN_NUMBER) begin
         if (overflowed) begin
            push_token(stt_pkg::KIND_OVF, '0, run_start, run_len, '0);
            mode = SCAN_ERROR;
         end else begin
            push_token(stt_pkg::KIND_NUMBER, value_acc[30:0], run_start, run_len, '0);
            mode = SCAN_IDLE;
         end
      end else if (mode == SCAN_IDENT) begin
         kind = stt_pkg::KIND_IDENT;
         for (int i = 0; i < stt_pkg::KW_COUNT; i++) begin
            if (run_len == stt_pkg::KW_LEN[i] &&
                prefix == stt_pkg::KW_TEXT[i][PREFIX_BITS-1:0])
               kind = stt_pkg::KIND_KW_BASE + 5'(i);
         end
         push_token(kind, '0, run_start, run_len, '0);
         mode = SCAN_IDLE;
      end
   endfunction

   function void note_request(stt_pkg::req_type r);
      logic [7:0]  c;
      logic [7:0]  lowered;
      logic [15:0] pos;
      logic [63:0] wide;
      int          base;
      bit          digit;
      bit          letter;
      bit          extend;
      bit          op_hit;
      c       = r.char_code;
      pos     = next_pos;
      base    = pending_tokens.size();
      digit   = c >= CH_ZERO && c <= CH_NINE;
      letter  = (c >= CH_UPPER_A && c <= CH_UPPER_Z) || (c >= CH_LOWER_A && c <= CH_LOWER_Z);
      lowered = (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? c + CASE_GAP : c;
      extend  = 1'b0;
      if (r.end_mark) begin
         close_run();
         push_token(stt_pkg::KIND_END, '0, pos, '0, '0);
         restart();
      end else begin
         next_pos = pos + 16'd1;
         if (mode == SCAN_NUMBER && digit) begin
            if (!overflowed) begin
               wide = 64'(value_acc) * 64'd10 + 64'(c - CH_ZERO);
               if (wide > 64'(stt_pkg::NUM_LIMIT))
                  overflowed = 1'b1;
               else
                  value_acc = wide[31:0];
            end
            extend = 1'b1;
         end else if (mode == SCAN_IDENT && (letter || digit || c == CH_UNDERSCORE)) begin
            if (run_len < stt_pkg::KEYWORD_MAX_LEN_DEF)
               prefix[8*run_len +: 8] = lowered;
            extend = 1'b1;
         end else begin
            close_run();
            if (mode == SCAN_IDLE) begin
               op_hit = 1'b0;
               for (int i = 0; i < stt_pkg::OP_COUNT; i++) begin
                  if (c == stt_pkg::OP_CHARS[i]) begin
                     push_token(5'(i), '0, pos, 16'd1, '0);
                     op_hit = 1'b1;
                  end
               end
               if (op_hit || c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
               end else if (digit) begin
                  mode       = SCAN_NUMBER;
                  value_acc  = 32'(c - CH_ZERO);
                  overflowed = 1'b0;
                  run_start  = pos;
                  run_len    = 16'd1;
                  prefix     = '0;
               end else if (letter || c == CH_UNDERSCORE) begin
                  mode       = SCAN_IDENT;
                  value_acc  = '0;
                  overflowed = 1'b0;
                  run_start  = pos;
                  run_len    = 16'd1;
                  prefix     = PREFIX_BITS'(lowered);
               end else begin
                  push_token(stt_pkg::KIND_BAD, '0, pos, 16'd1, c);
                  mode = SCAN_ERROR;
               end
            end
         end
         if (extend && run_len != stt_pkg::LEN_SAT)
            run_len = run_len + 16'd1;
      end
      if (pending_tokens.size() > base)
         pending_tokens[pending_tokens.size() - 1].last = 1'b1;
   endfunction

   function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         failures++;
      end
   endfunction

   function void check_token(stt_pkg::rsp_type got);
      stt_pkg::rsp_type want;
      if (pending_tokens.size() == 0) begin
         $error("token_kind: expected none, got %0d at %0d", got.token_kind, got.token_start);
         failures++;
         return;
      end
      want = pending_tokens.pop_front();
      compare_field("token_kind", 32'(want.token_kind), 32'(got.token_kind));
      compare_field("number_value", 32'(want.number_value), 32'(got.number_value));
      compare_field("token_start", 32'(want.token_start), 32'(got.token_start));
      compare_field("token_length", 32'(want.token_length), 32'(got.token_length));
      compare_field("bad_char", 32'(want.bad_char), 32'(got.bad_char));
      compare_field("last", 32'(want.last), 32'(got.last));
   endfunction
endclass

module source_text_tokenizer_test;

   localparam int RANDOM_ITEMS = 1150;
   localparam int LONG_RUN     = 40;
   localparam int HOLD_OFF     = 400;
   localparam int DRAIN_CYCLES = 40;
   localparam int CYCLE_LIMIT  = 1000000;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   stt_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   stt_pkg::rsp_type rsp_data;

   token_scoreboard board;
   int  cycle_count = 0;
   int  items_sent = 0;
   bit  no_gaps = 1'b0;
   bit  sender_calm = 1'b0;
   bit  receiver_calm = 1'b0;
   bit  hold_off_request = 1'b0;

   source_text_tokenizer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("source_text_tokenizer_test: FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            board.check_token(rsp_data);
         if (req_valid && !req_stall)
            board.note_request(req_data);
      end
   end

   initial begin
      int hold;
      rsp_stall = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if ($urandom_range(0, 39) == 0)
            receiver_calm = !receiver_calm;
         hold = receiver_calm ? 0 : $urandom_range(0, 18);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            hold = HOLD_OFF;
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (rsp_valid !== 1'b1) @(posedge clock);
         @(negedge clock);
      end
   end

   task automatic send_request(logic [7:0] c, bit end_mark);
      int gap;
      if (!no_gaps && $urandom_range(0, 39) == 0)
         sender_calm = !sender_calm;
      gap = (no_gaps || sender_calm) ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{char_code: c, end_mark: end_mark};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++)
         send_request(s[i], 1'b0);
   endtask

   task automatic send_end();
      send_request(8'($urandom), 1'b1);
   endtask

   function automatic logic [7:0] random_ident_char(bit lead);
      logic [7:0] c;
      case ($urandom_range(lead ? 1 : 0, 3))
         0:       c = CH_ZERO + 8'($urandom_range(0, 9));
         1:       c = CH_UPPER_A + 8'($urandom_range(0, 25));
         2:       c = CH_LOWER_A + 8'($urandom_range(0, 25));
         default: c = CH_UNDERSCORE;
      endcase
      return c;
   endfunction

   task automatic send_decimal(logic [63:0] v, int zeros);
      logic [7:0] digits[$];
      do begin
         digits.push_front(CH_ZERO + 8'(v % 10));
         v = v / 10;
      end while (v != 0);
      repeat (zeros) send_request(CH_ZERO, 1'b0);
      foreach (digits[i])
         send_request(digits[i], 1'b0);
   endtask

   task automatic send_separator();
      int ws;
      if ($urandom_range(0, 1) == 0) begin
         send_request(stt_pkg::OP_CHARS[$urandom_range(0, stt_pkg::OP_COUNT - 1)], 1'b0);
      end else begin
         ws = $urandom_range(CH_TAB - 1, CH_CR);
         send_request(ws == CH_TAB - 1 ? CH_SPACE : 8'(ws), 1'b0);
      end
   endtask

   task automatic emit_token();
      logic [7:0]  ch;
      logic [63:0] v;
      int          k;
      case ($urandom_range(0, 9))
         0, 1: begin
            k = $urandom_range(0, stt_pkg::KW_COUNT - 1);
            for (int j = 0; j < stt_pkg::KW_LEN[k]; j++) begin
               ch = stt_pkg::KW_TEXT[k][8*j +: 8];
               if ($urandom_range(0, 2) == 0)
                  ch = ch - CASE_GAP;
               send_request(ch, 1'b0);
            end
         end
         2, 3: begin
            send_request(random_ident_char(1'b1), 1'b0);
            repeat ($urandom_range(0, 7)) send_request(random_ident_char(1'b0), 1'b0);
         end
         4, 5: begin
            case ($urandom_range(0, 4))
               0, 1:    v = 64'($urandom_range(0, 999));
               2:       v = 64'(stt_pkg::NUM_LIMIT) - 64'($urandom_range(0, 9));
               3:       v = 64'(stt_pkg::NUM_LIMIT) + 64'($urandom_range(1, 10));
               default: v = {32'($urandom), 32'($urandom)};
            endcase
            send_decimal(v, $urandom_range(0, 9) == 0 ? $urandom_range(1, 3) : 0);
         end
         6, 7:
            send_request(stt_pkg::OP_CHARS[$urandom_range(0, stt_pkg::OP_COUNT - 1)], 1'b0);
         default:
            send_separator();
      endcase
      if ($urandom_range(0, 3) != 0)
         send_separator();
   endtask

   task automatic send_long_run(bit digits);
      send_request(digits ? CH_ZERO + 8'd1 : CH_UNDERSCORE, 1'b0);
      repeat (LONG_RUN - 1)
         send_request(digits ? CH_ZERO + 8'($urandom_range(0, 9)) : random_ident_char(1'b0),
                      1'b0);
      send_text(";");
      send_end();
   endtask

   initial begin
      int  random_start;
      bit  pressure_done;
      board         = new();
      pressure_done = 1'b0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_text("+-*/();");
      send_end();
      send_request(8'hFF, 1'b0);
      send_text("a");
      send_end();
      send_text("2147483647");
      send_end();
      send_request(CH_UNDERSCORE, 1'b0);
      send_request(8'h00, 1'b0);
      send_end();

      no_gaps = 1'b1;
      send_long_run(1'b0);
      send_long_run(1'b1);
      no_gaps = 1'b0;

      random_start = items_sent;
      while (items_sent - random_start < RANDOM_ITEMS) begin
         repeat ($urandom_range(1, 20)) begin
            if ($urandom_range(0, 29) == 0)
               send_request(8'($urandom_range(0, 255)), 1'b0);
            else
               emit_token();
         end
         send_end();
         if (!pressure_done && items_sent - random_start > RANDOM_ITEMS / 3) begin
            hold_off_request = 1'b1;
            no_gaps          = 1'b1;
            repeat (60)
               send_request(stt_pkg::OP_CHARS[$urandom_range(0, stt_pkg::OP_COUNT - 1)],
                            1'b0);
            send_end();
            no_gaps       = 1'b0;
            pressure_done = 1'b1;
         end
      end
      req_valid <= 1'b0;

      while (board.pending_tokens.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.failures == 0)
         $display("source_text_tokenizer_test: PASS");
      else
         $display("source_text_tokenizer_test: FAIL");
      $finish;
   end

endmodule

[filelist.f]
src/stt_pkg.sv
src/stt_scan.sv
src/stt_queue.sv
src/source_text_tokenizer.sv
tb/source_text_tokenizer_test.sv
